>>> sv/idl_pkg.sv
`default_nettype none
package idl_pkg;
    localparam logic [2:0] K_ADD_FRONT = 3'd0;
    localparam logic [2:0] K_PUSH_BACK = 3'd1;
    localparam logic [2:0] K_INSERT    = 3'd2;
    localparam logic [2:0] K_POP_FRONT = 3'd3;
    localparam logic [2:0] K_SHIFT     = 3'd4;
    localparam logic [2:0] K_REMOVE    = 3'd5;
    localparam logic [2:0] K_READ      = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // shift commands for the cell chain
    localparam logic [1:0] SH_NONE  = 2'd0;
    localparam logic [1:0] SH_OPEN  = 2'd1;
    localparam logic [1:0] SH_CLOSE = 2'd2;

    typedef struct packed {
        logic       load;     // capture result word and status
        logic [1:0] shift;    // chain operation
        logic       inc;
        logic       dec;
        logic       done;     // result strobe
        logic [1:0] status;
        logic       take;     // report read word
    } t_cmd;
endpackage
`default_nettype wire

>>> sv/idl_ctrl.sv
`default_nettype none
module idl_ctrl #(
    parameter int CW = 7,
    parameter int CAPACITY = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire [2:0]    i_kind,
    input  wire [5:0]    i_index,
    input  wire [CW-1:0] i_fill,
    output logic         o_busy,
    output idl_pkg::t_cmd o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DONE = 1'b1;
    // compare width that holds both the index and the fill
    localparam int IW = (CW > 6) ? CW : 6;
    logic r_state;
    logic n_state;
    logic full, empty, rng;

    assign full  = i_fill >= CW'(CAPACITY);
    assign empty = i_fill == '0;
    assign rng   = IW'(i_index) >= IW'(i_fill);
    assign o_busy = 1'b0;

    // decode one word into chain commands; result leaves next cycle
    always_comb begin
        o_cmd = '0;
        n_state = S_IDLE;
        o_cmd.done = (r_state == S_DONE);
        if (i_start) begin
            o_cmd.load = 1'b1;
            n_state = S_DONE;
            o_cmd.status = idl_pkg::ST_OK;
            case (i_kind)
                idl_pkg::K_ADD_FRONT, idl_pkg::K_PUSH_BACK: begin
                    if (full) o_cmd.status = idl_pkg::ST_FULL;
                    else begin
                        o_cmd.shift = idl_pkg::SH_OPEN;
                        o_cmd.inc = 1'b1;
                    end
                end
                idl_pkg::K_INSERT: begin
                    if (full) o_cmd.status = idl_pkg::ST_FULL;
                    else if (empty) o_cmd.status = idl_pkg::ST_EMPTY;
                    else if (rng) o_cmd.status = idl_pkg::ST_RANGE;
                    else begin
                        o_cmd.shift = idl_pkg::SH_OPEN;
                        o_cmd.inc = 1'b1;
                    end
                end
                idl_pkg::K_POP_FRONT, idl_pkg::K_SHIFT: begin
                    if (empty) o_cmd.status = idl_pkg::ST_EMPTY;
                    else begin
                        o_cmd.shift = idl_pkg::SH_CLOSE;
                        o_cmd.dec = 1'b1;
                        o_cmd.take = 1'b1;
                    end
                end
                idl_pkg::K_REMOVE, idl_pkg::K_READ: begin
                    if (empty) o_cmd.status = idl_pkg::ST_EMPTY;
                    else if (rng) o_cmd.status = idl_pkg::ST_RANGE;
                    else begin
                        o_cmd.take = 1'b1;
                        if (i_kind == idl_pkg::K_REMOVE) begin
                            o_cmd.shift = idl_pkg::SH_CLOSE;
                            o_cmd.dec = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule
`default_nettype wire

>>> sv/idl_data.sv
`default_nettype none
module idl_data #(
    parameter int CW = 7,
    parameter int CAPACITY = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  idl_pkg::t_cmd i_cmd,
    input  wire [2:0]    i_kind,
    input  wire [5:0]    i_index,
    input  wire signed [31:0] i_value,
    output logic [CW-1:0] o_fill,
    output logic signed [31:0] o_result_value,
    output logic [1:0]   o_status
);
    logic [31:0] r_cell [CAPACITY];
    logic [CW-1:0] r_fill;
    logic [CW-1:0] pos;   // position of the gap
    logic [31:0] pick;

    // gap position per kind
    always_comb begin
        case (i_kind)
            idl_pkg::K_ADD_FRONT, idl_pkg::K_POP_FRONT: pos = '0;
            idl_pkg::K_PUSH_BACK: pos = r_fill;
            idl_pkg::K_INSERT: pos = CW'(i_index) + CW'(1);
            idl_pkg::K_SHIFT: pos = r_fill - CW'(1);
            default: pos = CW'(i_index);
        endcase
    end

    // read word select
    always_comb begin
        pick = '0;
        for (int i = 0; i < CAPACITY; i++)
            if (pos == CW'(i)) pick = r_cell[i];
    end

    // cell chain: each cell takes its neighbor or the new word
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.shift == idl_pkg::SH_OPEN) begin
                if (CW'(i) == pos) r_cell[i] <= i_value;
                else if (CW'(i) > pos && i > 0) r_cell[i] <= r_cell[(i > 0) ? i-1 : 0];
            end else if (i_cmd.shift == idl_pkg::SH_CLOSE) begin
                if (CW'(i) >= pos && i < CAPACITY-1)
                    r_cell[i] <= r_cell[(i < CAPACITY-1) ? i+1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fill <= '0;
        else if (i_cmd.inc) r_fill <= r_fill + CW'(1);
        else if (i_cmd.dec) r_fill <= r_fill - CW'(1);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_result_value <= i_cmd.take ? pick : '0;
            o_status <= i_cmd.status;
        end
    end
    assign o_fill = r_fill;
endmodule
`default_nettype wire

>>> sv/indexed_deque_list_top.sv
`default_nettype none
// Indexed deque: ordered list of signed words kept in a chain of cells.
// Command channel: raise i_start with i_kind, i_index, i_value; the word
// is taken at any edge with i_start high and o_busy low. o_busy is always
// low, so one command is taken every cycle.
// Result: o_done pulses for one cycle, the cycle after the command was
// taken, with o_result_value, o_status and o_count. Throughput
// 1 command per cycle; inserts and removes move every later
// cell by one place in that same cycle.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset (synchronous, i_rst_n low) empties the list at once; cell
// contents are left as they are and never read before written.
// Status: ok, empty, out of range, full; a failing command changes nothing.
module indexed_deque_list_top #(
    parameter int CAPACITY = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire [2:0]   i_kind,
    input  wire [5:0]   i_index,
    input  wire signed [31:0] i_value,
    output logic        o_done,
    output logic signed [31:0] o_result_value,
    output logic [1:0]  o_status,
    output logic [6:0]  o_count
);
    localparam int CW = $clog2(CAPACITY + 1);
    idl_pkg::t_cmd cmd;
    logic [CW-1:0] fill;

    idl_ctrl #(.CW(CW), .CAPACITY(CAPACITY)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_kind(i_kind),
        .i_index(i_index), .i_fill(fill), .o_busy(o_busy), .o_cmd(cmd)
    );
    idl_data #(.CW(CW), .CAPACITY(CAPACITY)) u_data (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_kind(i_kind),
        .i_index(i_index), .i_value(i_value), .o_fill(fill),
        .o_result_value(o_result_value), .o_status(o_status)
    );
    assign o_done = cmd.done;
    assign o_count = 7'(fill);

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= CW'(CAPACITY)) else $error("fill over capacity");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_done) else $error("missing result");
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != idl_pkg::ST_OK) |-> o_result_value == 0)
        else $error("error result not zero");
endmodule
`default_nettype wire

>>> bench/indexed_deque_list_top_tb.sv
`default_nettype none
module indexed_deque_list_top_tb;
    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] K_UNUSED = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [2:0]  i_kind;
    logic [5:0]  i_index;
    logic signed [31:0] i_value;
    wire         o_busy;
    wire         o_done;
    wire signed [31:0] o_result_value;
    wire [1:0]   o_status;
    wire [6:0]   o_count;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
        logic [6:0]  count;
    } t_list_reply;

    // shadow copy of the list contents
    logic [31:0] shadow_list[DEPTH];
    int unsigned shadow_fill;
    t_list_reply pending_replies[$];
    int unsigned mismatch_cnt;
    int unsigned idle_cnt;
    bit          idle_on;

    indexed_deque_list_top #(.CAPACITY(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_kind(i_kind), .i_index(i_index), .i_value(i_value),
        .o_done(o_done), .o_result_value(o_result_value),
        .o_status(o_status), .o_count(o_count)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // list behavior: returns the reply and updates the shadow list
    function automatic t_list_reply apply_list_op(logic [2:0] kind, logic [5:0] idx,
                                                  logic [31:0] val);
        t_list_reply r;
        bit is_full;
        r.word = '0;
        r.status = idl_pkg::ST_OK;
        is_full = (shadow_fill >= DEPTH);
        case (kind)
            idl_pkg::K_ADD_FRONT, idl_pkg::K_PUSH_BACK: begin
                if (is_full) begin
                    r.status = idl_pkg::ST_FULL;
                end else if (kind == idl_pkg::K_ADD_FRONT) begin
                    for (int i = shadow_fill; i > 0; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[0] = val;
                    shadow_fill++;
                end else begin
                    shadow_list[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            idl_pkg::K_INSERT: begin
                if (is_full) r.status = idl_pkg::ST_FULL;
                else if (shadow_fill == 0) r.status = idl_pkg::ST_EMPTY;
                else if (idx >= shadow_fill) r.status = idl_pkg::ST_RANGE;
                else begin
                    for (int i = shadow_fill; i > idx + 1; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[idx+1] = val;
                    shadow_fill++;
                end
            end
            idl_pkg::K_POP_FRONT, idl_pkg::K_SHIFT: begin
                if (shadow_fill == 0) r.status = idl_pkg::ST_EMPTY;
                else if (kind == idl_pkg::K_POP_FRONT) begin
                    r.word = shadow_list[0];
                    for (int i = 0; i + 1 < shadow_fill; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_fill--;
                end else begin
                    r.word = shadow_list[shadow_fill-1];
                    shadow_fill--;
                end
            end
            idl_pkg::K_REMOVE, idl_pkg::K_READ: begin
                if (shadow_fill == 0) r.status = idl_pkg::ST_EMPTY;
                else if (idx >= shadow_fill) r.status = idl_pkg::ST_RANGE;
                else begin
                    r.word = shadow_list[idx];
                    if (kind == idl_pkg::K_REMOVE) begin
                        for (int i = idx; i + 1 < shadow_fill; i++)
                            shadow_list[i] = shadow_list[i+1];
                        shadow_fill--;
                    end
                end
            end
            default: ;
        endcase
        r.count = shadow_fill[6:0];
        return r;
    endfunction

    // send one word, with random idle cycles ahead of it while idle_on is set
    task automatic send_word(logic [2:0] kind, logic [5:0] idx, logic [31:0] val);
        while (idle_on && $urandom_range(99) < 30) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_kind  <= kind;
        i_index <= idx;
        i_value <= val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_replies.push_back(apply_list_op(kind, idx, val));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // random in-range index, or any index a tenth of the time and always on an empty list
    function automatic logic [5:0] pick_index();
        if (shadow_fill != 0 && $urandom_range(9) != 0)
            return 6'($urandom_range(shadow_fill - 1));
        return 6'($urandom);
    endfunction

    task automatic test_empty_list();
        send_word(idl_pkg::K_POP_FRONT, 6'd0, 32'd0);
        send_word(idl_pkg::K_SHIFT, 6'd0, 32'd0);
        send_word(idl_pkg::K_REMOVE, 6'd0, 32'd0);
        send_word(idl_pkg::K_READ, 6'd63, 32'd0);
        send_word(idl_pkg::K_INSERT, 6'd0, 32'h1234_5678);
        send_word(K_UNUSED, 6'd5, 32'hFFFF_FFFF);
    endtask

    task automatic test_basic_ops();
        send_word(idl_pkg::K_PUSH_BACK, 6'd63, 32'h7FFF_FFFF);
        send_word(idl_pkg::K_ADD_FRONT, 6'd0, 32'h8000_0000);
        send_word(idl_pkg::K_INSERT, 6'd1, 32'hFFFF_FFFF);   // after last entry
        send_word(idl_pkg::K_INSERT, 6'd0, 32'h0000_0000);
        send_word(idl_pkg::K_READ, 6'd3, 32'd0);
        send_word(idl_pkg::K_READ, 6'd4, 32'd0);              // out of range
        send_word(idl_pkg::K_REMOVE, 6'd1, 32'd0);
        send_word(idl_pkg::K_REMOVE, 6'd63, 32'd0);
        send_word(idl_pkg::K_INSERT, 6'd63, 32'd1);
        send_word(idl_pkg::K_POP_FRONT, 6'd0, 32'd0);
        send_word(idl_pkg::K_SHIFT, 6'd0, 32'd0);
        send_word(idl_pkg::K_SHIFT, 6'd0, 32'd0);             // last entry leaves
        send_word(idl_pkg::K_READ, 6'd0, 32'd0);
    endtask

    task automatic test_full_list();
        while (shadow_fill < DEPTH) send_word(idl_pkg::K_PUSH_BACK, 6'($urandom), $urandom);
        send_word(idl_pkg::K_ADD_FRONT, 6'd0, 32'd5);
        send_word(idl_pkg::K_PUSH_BACK, 6'd0, 32'd5);
        send_word(idl_pkg::K_INSERT, 6'd10, 32'd5);
        send_word(idl_pkg::K_READ, 6'd63, 32'd0);
        send_word(idl_pkg::K_REMOVE, 6'd63, 32'd0);
        while (shadow_fill > 0) send_word(idl_pkg::K_POP_FRONT, 6'd0, 32'd0);
    endtask

    // random traffic biased to grow or shrink the list in phases
    task automatic test_random_traffic(int unsigned n_words);
        bit growing;
        logic [2:0] kind;
        growing = 1'b1;
        for (int unsigned n = 0; n < n_words; n++) begin
            if (shadow_fill >= DEPTH - 2 && $urandom_range(3) == 0) growing = 1'b0;
            if (shadow_fill <= 1 && $urandom_range(3) == 0) growing = 1'b1;
            idle_on = !(n >= 300 && n < 450);
            if (n == 600) wait_drained();
            if ($urandom_range(99) < 60)
                kind = growing ? 3'($urandom_range(2)) : 3'($urandom_range(5, 3));
            else
                kind = 3'($urandom_range(7));
            send_word(kind, pick_index(), $urandom);
        end
    endtask

    // check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_list_reply want;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result at %0t", $time);
            end else begin
                want = pending_replies.pop_front();
                if (o_result_value !== want.word || o_status !== want.status ||
                    o_count !== want.count) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 want.word, want.status, want.count,
                                 o_result_value, o_status, o_count);
                end
            end
        end
    end

    // watchdog on cycles without progress
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_kind = '0;
        i_index = '0;
        i_value = '0;
        shadow_fill = 0;
        mismatch_cnt = 0;
        idle_cnt = 0;
        idle_on = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random_traffic(950);
        wait_drained();
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
